[hdl/event_sensor_byte_decoder_top_macros.svh]
// Assertion macros used by the checker file of the event byte decoder
`ifndef EVENT_SENSOR_BYTE_DECODER_TOP_MACROS_SVH
`define EVENT_SENSOR_BYTE_DECODER_TOP_MACROS_SVH

// checked while out of reset
`define ESBD_ASSERT(name, prop, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ESBD_ASSERT_ALWAYS(name, prop, msg) \
name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/esbd_pkg.sv]
// Shared types, constants and helpers for the event byte decoder
`timescale 1ns / 1ps
`default_nettype none

package esbd_pkg;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_TS16 = 2'd1,
		MODE_TS24 = 2'd2,
		MODE_TS32 = 2'd3
	} stamp_mode_t;

	localparam stamp_mode_t MODE_RESET = MODE_TS24;

	localparam logic [7:0] HIGH_BIT = 8'h80;
	localparam logic [7:0] LOW_BITS = 8'h7F;

	// event on its way from the framer to the time accumulator
	typedef struct packed {
		logic [6:0]  x;
		logic [6:0]  y;
		logic        pol;
		logic [32:0] delta;
	} event_t;

	function automatic logic [2:0] stamp_bytes(stamp_mode_t m);
		logic [2:0] n;
		case (m)
			MODE_NONE: n = 3'd0;
			MODE_TS16: n = 3'd2;
			MODE_TS24: n = 3'd3;
			MODE_TS32: n = 3'd4;
			default:   n = 3'd0;
		endcase
		return n;
	endfunction

	function automatic logic [31:0] stamp_mask(stamp_mode_t m);
		logic [31:0] k;
		case (m)
			MODE_NONE: k = 32'h0000_0000;
			MODE_TS16: k = 32'h0000_FFFF;
			MODE_TS24: k = 32'h00FF_FFFF;
			MODE_TS32: k = 32'hFFFF_FFFF;
			default:   k = 32'h0000_0000;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

[hdl/esbd_framer.sv]
// Byte framer: tracks position in the event, gathers the stamp, computes the time delta
`timescale 1ns / 1ps
`default_nettype none

module esbd_framer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire esbd_pkg::stamp_mode_t mode,
	input  wire logic                byte_valid_s1,
	input  wire logic [7:0]          link_byte_s1,
	output logic                     consume,
	input  wire logic                ev_take,
	output logic                     ev_valid_s2,
	output esbd_pkg::event_t         ev_s2
);
	import esbd_pkg::*;

	logic [2:0]  pos_q;
	logic [2:0]  pos_d;
	logic [2:0]  pos_inc;
	logic [2:0]  total;
	logic [6:0]  row_q;
	logic [6:0]  row_d;
	logic [7:0]  col_q;
	logic [7:0]  col_d;
	logic [31:0] gather_q;
	logic [31:0] gather_d;
	logic [31:0] prev_q;
	logic [31:0] stamp;
	logic [32:0] delta;
	logic        done;
	logic        s2_free;
	logic        fire;

	assign total = 3'd2 + stamp_bytes(mode);

	always_comb begin
		pos_d    = pos_q;
		row_d    = row_q;
		col_d    = col_q;
		gather_d = gather_q;
		done     = 1'b0;
		pos_inc  = pos_q + 3'd1;
		if (pos_q == 3'd0) begin
			// high bit set while waiting for a row byte: drop it to resync
			if ((link_byte_s1 & HIGH_BIT) == 8'h00) begin
				row_d = 7'(link_byte_s1 & LOW_BITS);
				pos_d = 3'd1;
			end
		end else begin
			if (pos_q == 3'd1) begin
				col_d    = link_byte_s1;
				gather_d = '0;
			end else begin
				gather_d = {gather_q[23:0], link_byte_s1};
			end
			// >= covers a mode change that shortened the current event
			if (pos_inc >= total) begin
				done  = 1'b1;
				pos_d = 3'd0;
			end else begin
				pos_d = pos_inc;
			end
		end
		stamp = gather_d & stamp_mask(mode);
		delta = (stamp > prev_q) ? {1'b0, stamp - prev_q} : {stamp, 1'b0};
	end

	assign s2_free = !ev_valid_s2 || ev_take;
	assign consume = byte_valid_s1 && (!done || s2_free);
	assign fire    = consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 3'd0;
			prev_q      <= '0;
			ev_valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				pos_q <= pos_d;
				if (done) begin
					prev_q <= stamp;
				end
			end
			if (fire && done) begin
				ev_valid_s2 <= 1'b1;
			end else if (ev_take) begin
				ev_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			row_q    <= row_d;
			col_q    <= col_d;
			gather_q <= gather_d;
		end
		if (fire && done) begin
			ev_s2.x     <= col_d[6:0];
			ev_s2.y     <= row_q;
			ev_s2.pol   <= col_d[7];
			ev_s2.delta <= delta;
		end
	end

endmodule

`default_nettype wire

[hdl/esbd_accum.sv]
// Running time accumulator and output register
`timescale 1ns / 1ps
`default_nettype none

module esbd_accum (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             ev_valid_s2,
	input  wire esbd_pkg::event_t ev_s2,
	output logic                  ev_take,
	input  wire logic             event_stall,
	output logic                  event_valid,
	output logic [6:0]            event_x,
	output logic [6:0]            event_y,
	output logic                  polarity,
	output logic [63:0]           event_time
);
	import esbd_pkg::*;

	logic        out_valid_q;
	logic [63:0] rt_q;
	logic [63:0] rt_d;
	logic [6:0]  x_q;
	logic [6:0]  y_q;
	logic        pol_q;

	assign ev_take = ev_valid_s2 && (!out_valid_q || !event_stall);

	// zero time (first event, or after a wrap) restarts at one
	assign rt_d = (rt_q == 64'd0) ? 64'd1 : rt_q + {31'd0, ev_s2.delta};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rt_q        <= '0;
		end else begin
			if (ev_take) begin
				out_valid_q <= 1'b1;
				rt_q        <= rt_d;
			end else if (!event_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_take) begin
			x_q   <= ev_s2.x;
			y_q   <= ev_s2.y;
			pol_q <= ev_s2.pol;
		end
	end

	assign event_valid = out_valid_q;
	assign event_x     = x_q;
	assign event_y     = y_q;
	assign polarity    = pol_q;
	assign event_time  = rt_q;

endmodule

`default_nettype wire

[hdl/event_sensor_byte_decoder_top.sv]
// Event-camera link byte decoder: top level
//
// Link channel: link_valid / link_stall / link_byte. A byte is taken at an
// edge with link_valid high and link_stall low. One byte per cycle while link_stall is low.
// Event channel: event_valid / event_stall with event_x, event_y, polarity
// and event_time. A word is taken at an edge with event_valid high and
// event_stall low.
// Config channel: cfg_valid / cfg_ready with stamp_mode; cfg_ready is always
// high. Write it only while the decoder is idle.
// Path: the last byte of an event is held in the input register, then in the
// framer's event register, then in the output register that drives event_valid.
// Throughput: one byte per cycle while link_stall is low, set by the framer; at
// most one event per two bytes.
// Stall: the input register, the framer's event register and the output
// register form a three-deep pipe; link_stall rises only when a finished
// event cannot move because all later stages are full and event_stall is high.
// Reset: clears framing, running time and last stamp; stamp_mode returns to
// 24-bit stamps.
`timescale 1ns / 1ps
`default_nettype none

module event_sensor_byte_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  stamp_mode,
	input  wire logic        link_valid,
	output logic             link_stall,
	input  wire logic [7:0]  link_byte,
	output logic             event_valid,
	input  wire logic        event_stall,
	output logic [6:0]       event_x,
	output logic [6:0]       event_y,
	output logic             polarity,
	output logic [63:0]      event_time
);
	import esbd_pkg::*;

	stamp_mode_t mode_q;
	logic        byte_valid_s1;
	logic [7:0]  link_byte_s1;
	logic        consume;
	logic        ev_take;
	logic        ev_valid_s2;
	event_t      ev_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= stamp_mode_t'(stamp_mode);
		end
	end

	assign link_stall = byte_valid_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (!link_stall) begin
			byte_valid_s1 <= link_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (link_valid && !link_stall) begin
			link_byte_s1 <= link_byte;
		end
	end

	esbd_framer u_framer (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode_q),
		.byte_valid_s1 (byte_valid_s1),
		.link_byte_s1  (link_byte_s1),
		.consume       (consume),
		.ev_take       (ev_take),
		.ev_valid_s2   (ev_valid_s2),
		.ev_s2         (ev_s2)
	);

	esbd_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.ev_valid_s2 (ev_valid_s2),
		.ev_s2       (ev_s2),
		.ev_take     (ev_take),
		.event_stall (event_stall),
		.event_valid (event_valid),
		.event_x     (event_x),
		.event_y     (event_y),
		.polarity    (polarity),
		.event_time  (event_time)
	);

endmodule

`default_nettype wire

[hdl/esbd_checker.sv]
// Port-level assertions for the event byte decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "event_sensor_byte_decoder_top_macros.svh"

module esbd_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        link_stall,
	input  wire logic        event_valid,
	input  wire logic        event_stall,
	input  wire logic [6:0]  event_x,
	input  wire logic [6:0]  event_y,
	input  wire logic        polarity,
	input  wire logic [63:0] event_time
);

	// the link only backs up when the event side is full and held
	`ESBD_ASSERT(a_link_stall_cause, link_stall |-> (event_valid && event_stall), "link stalled while event side could drain")

	// a held event word keeps its value
	`ESBD_ASSERT(a_event_hold, (event_valid && event_stall) |=> (event_valid && $stable(event_time) && $stable(event_x) && $stable(event_y) && $stable(polarity)), "held event word changed")

	// in reset nothing is offered and nothing is refused
	`ESBD_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> (!event_valid && !link_stall), "outputs active in reset")

endmodule

bind event_sensor_byte_decoder_top esbd_checker u_esbd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.link_stall  (link_stall),
	.event_valid (event_valid),
	.event_stall (event_stall),
	.event_x     (event_x),
	.event_y     (event_y),
	.polarity    (polarity),
	.event_time  (event_time)
);

`default_nettype wire
